[hdl/rcpa_pkg.sv]
// ----------------------------------------------------------------------------
// rcpa_pkg
// shared types, constants and count helpers of the refcounted page allocator
// ----------------------------------------------------------------------------
package rcpa_pkg;

   // sizing
   localparam int NUM_PAGES   = 32768;
   localparam int COUNT_WIDTH = 16;
   localparam int PAGE_WIDTH  = 15;
   localparam int OUT_WIDTH   = 16;
   localparam int ADDR_WIDTH  = $clog2(NUM_PAGES);
   localparam int TOP_WIDTH   = $clog2(NUM_PAGES + 1);

   // register file
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [0:0] REG_FIRST_USABLE = 1'b0;

   typedef logic signed [COUNT_WIDTH-1:0] count_type;
   typedef logic [PAGE_WIDTH-1:0]         page_type;

   localparam count_type CNT_MAX  = count_type'({1'b0, {(COUNT_WIDTH-1){1'b1}}});
   localparam count_type CNT_MIN  = count_type'({1'b1, {(COUNT_WIDTH-1){1'b0}}});
   localparam count_type CNT_ONE  = count_type'(1);
   localparam count_type CNT_ZERO = count_type'(0);

   typedef enum logic [2:0] {
      OP_ALLOC    = 3'd0,
      OP_FREE     = 3'd1,
      OP_REF_UP   = 3'd2,
      OP_REF_DOWN = 3'd3,
      OP_COW_COPY = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OOM  = 2'd1,
      ST_BAD  = 2'd2,
      ST_FULL = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_FILL
   } state_type;

   typedef struct packed {
      logic issue;
      logic commit;
      logic fill;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_valid;
      logic fill_needed;
      logic clear_last;
   } dp_status_type;

   function automatic count_type cnt_inc(input count_type c);
      return (c == CNT_MAX) ? c : count_type'(c + CNT_ONE);
   endfunction

   function automatic count_type cnt_dec(input count_type c);
      return (c == CNT_MIN) ? c : count_type'(c - CNT_ONE);
   endfunction

   // low bits of the sign-extended count
   function automatic logic [OUT_WIDTH-1:0] cnt_out(input count_type c);
      logic signed [31:0] w;
      w = 32'(c);
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

[hdl/rcpa_ctrl.sv]
// ----------------------------------------------------------------------------
// rcpa_ctrl
// sequencer: clearing pass, request issue, commit and second count write
// ----------------------------------------------------------------------------
module rcpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   input  rcpa_pkg::dp_status_type stat,
   output rcpa_pkg::dp_cmd_type   cmd
);

   rcpa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rcpa_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = rcpa_pkg::S_IDLE;
            end
         end
         rcpa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.issue = 1'b1;
               state_in  = rcpa_pkg::S_EXEC;
            end
         end
         rcpa_pkg::S_EXEC: begin
            // wait for the output slot
            if (!stat.rsp_valid || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = stat.fill_needed ? rcpa_pkg::S_FILL : rcpa_pkg::S_IDLE;
            end
         end
         rcpa_pkg::S_FILL: begin
            cmd.fill = 1'b1;
            state_in = rcpa_pkg::S_IDLE;
         end
         default: begin
            state_in = rcpa_pkg::S_CLEAR;
         end
      endcase
   end

   a_fill_after_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> $past(cmd.commit))
      else $error("second count write without a preceding commit");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!stat.rsp_valid || !rsp_stall))
      else $error("commit into an occupied output slot");

   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (req_stall && !cmd.issue))
      else $error("request taken during clearing pass");

endmodule

[hdl/rcpa_datapath.sv]
// ----------------------------------------------------------------------------
// rcpa_datapath
// count table, free stack, stack top, op evaluation and result register
// ----------------------------------------------------------------------------
module rcpa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rcpa_pkg::dp_cmd_type                cmd,
   output rcpa_pkg::dp_status_type             stat,
   input  logic [2:0]                          req_op,
   input  logic [rcpa_pkg::PAGE_WIDTH-1:0]     req_page,
   input  logic [rcpa_pkg::PAGE_WIDTH-1:0]     first_usable_page,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [rcpa_pkg::PAGE_WIDTH-1:0]     rsp_result_page,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_copy_needed,
   output logic signed [rcpa_pkg::OUT_WIDTH-1:0] rsp_ref_count
);

   // memories
   rcpa_pkg::count_type cnt_mem [rcpa_pkg::NUM_PAGES];
   rcpa_pkg::page_type  stk_mem [rcpa_pkg::NUM_PAGES];

   // control state
   logic [rcpa_pkg::TOP_WIDTH-1:0]  top_ff;
   logic [rcpa_pkg::ADDR_WIDTH-1:0] clear_ff;
   logic                            rsp_valid_ff;

   // request and read data
   logic [2:0]          op_ff;
   rcpa_pkg::page_type  page_ff;
   rcpa_pkg::count_type cnt_rd_ff;
   rcpa_pkg::page_type  stk_rd_ff;
   rcpa_pkg::page_type  np_ff;

   // result payload
   rcpa_pkg::page_type           rsp_page_ff;
   rcpa_pkg::status_code_type    rsp_status_ff;
   logic                         rsp_copy_ff;
   logic [rcpa_pkg::OUT_WIDTH-1:0] rsp_count_ff;

   // evaluation
   rcpa_pkg::page_type              res_page;
   rcpa_pkg::status_code_type       res_status;
   logic                            res_copy;
   rcpa_pkg::count_type             res_count;
   logic                            cnt_we_c;
   logic [rcpa_pkg::ADDR_WIDTH-1:0] cnt_waddr_c;
   rcpa_pkg::count_type             cnt_wdata_c;
   logic                            stk_we_c;
   logic [rcpa_pkg::TOP_WIDTH-1:0]  top_in;
   logic                            fill_c;
   logic                            page_valid;
   logic                            np_valid;
   logic                            stack_empty;
   logic                            stack_full;
   logic                            same_page;
   rcpa_pkg::count_type             cnt_inc_v;
   rcpa_pkg::count_type             cnt_dec_v;

   // count write port
   logic                            cnt_we;
   logic [rcpa_pkg::ADDR_WIDTH-1:0] cnt_waddr;
   rcpa_pkg::count_type             cnt_wdata;

   always_comb begin
      page_valid  = 32'(page_ff) < 32'(rcpa_pkg::NUM_PAGES);
      np_valid    = 32'(stk_rd_ff) < 32'(rcpa_pkg::NUM_PAGES);
      stack_empty = top_ff == '0;
      stack_full  = top_ff == rcpa_pkg::TOP_WIDTH'(rcpa_pkg::NUM_PAGES);
      same_page   = stk_rd_ff == page_ff;
      cnt_inc_v   = rcpa_pkg::cnt_inc(cnt_rd_ff);
      cnt_dec_v   = rcpa_pkg::cnt_dec(cnt_rd_ff);

      res_page    = page_ff;
      res_status  = rcpa_pkg::ST_OK;
      res_copy    = 1'b0;
      res_count   = cnt_rd_ff;
      cnt_we_c    = 1'b0;
      cnt_waddr_c = rcpa_pkg::ADDR_WIDTH'(page_ff);
      cnt_wdata_c = cnt_rd_ff;
      stk_we_c    = 1'b0;
      top_in      = top_ff;
      fill_c      = 1'b0;

      if (op_ff == rcpa_pkg::OP_ALLOC) begin
         if (stack_empty) begin
            res_page   = '0;
            res_status = rcpa_pkg::ST_OOM;
            res_count  = rcpa_pkg::CNT_ZERO;
         end else begin
            top_in      = top_ff - rcpa_pkg::TOP_WIDTH'(1);
            res_page    = stk_rd_ff;
            res_count   = rcpa_pkg::CNT_ONE;
            cnt_we_c    = np_valid;
            cnt_waddr_c = rcpa_pkg::ADDR_WIDTH'(stk_rd_ff);
            cnt_wdata_c = rcpa_pkg::CNT_ONE;
         end
      end else if (!page_valid) begin
         res_status = rcpa_pkg::ST_BAD;
         res_count  = rcpa_pkg::CNT_ZERO;
      end else begin
         case (op_ff)
            rcpa_pkg::OP_FREE: begin
               if (page_ff < first_usable_page) begin
                  res_status = rcpa_pkg::ST_BAD;
               end else begin
                  cnt_we_c    = 1'b1;
                  cnt_wdata_c = cnt_dec_v;
                  res_count   = cnt_dec_v;
                  if (cnt_dec_v <= rcpa_pkg::CNT_ZERO) begin
                     if (stack_full) begin
                        res_status = rcpa_pkg::ST_FULL;
                     end else begin
                        stk_we_c = 1'b1;
                        top_in   = top_ff + rcpa_pkg::TOP_WIDTH'(1);
                     end
                  end
               end
            end
            rcpa_pkg::OP_REF_UP: begin
               cnt_we_c    = 1'b1;
               cnt_wdata_c = cnt_inc_v;
               res_count   = cnt_inc_v;
            end
            rcpa_pkg::OP_REF_DOWN: begin
               cnt_we_c    = 1'b1;
               cnt_wdata_c = cnt_dec_v;
               res_count   = cnt_dec_v;
            end
            rcpa_pkg::OP_COW_COPY: begin
               if (cnt_rd_ff <= rcpa_pkg::CNT_ONE) begin
                  res_status = rcpa_pkg::ST_OK;
               end else if (stack_empty) begin
                  res_status = rcpa_pkg::ST_OOM;
               end else begin
                  top_in      = top_ff - rcpa_pkg::TOP_WIDTH'(1);
                  res_page    = stk_rd_ff;
                  res_copy    = 1'b1;
                  cnt_we_c    = 1'b1;
                  // popped page equal to the old one: set to 1 then decremented
                  cnt_wdata_c = same_page ? rcpa_pkg::CNT_ZERO : cnt_dec_v;
                  res_count   = cnt_wdata_c;
                  fill_c      = np_valid && !same_page;
               end
            end
            default: begin
               res_status = rcpa_pkg::ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      cnt_we    = cmd.clear || cmd.fill || (cmd.commit && cnt_we_c);
      cnt_waddr = cnt_waddr_c;
      cnt_wdata = cnt_wdata_c;
      if (cmd.clear) begin
         cnt_waddr = clear_ff;
         cnt_wdata = rcpa_pkg::CNT_ZERO;
      end else if (cmd.fill) begin
         cnt_waddr = rcpa_pkg::ADDR_WIDTH'(np_ff);
         cnt_wdata = rcpa_pkg::CNT_ONE;
      end
   end

   // count table
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         cnt_rd_ff <= cnt_mem[rcpa_pkg::ADDR_WIDTH'(req_page)];
      end
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         stk_rd_ff <= stk_mem[rcpa_pkg::ADDR_WIDTH'(top_ff - rcpa_pkg::TOP_WIDTH'(1))];
      end
      if (cmd.commit && stk_we_c) begin
         stk_mem[rcpa_pkg::ADDR_WIDTH'(top_ff)] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clear_ff <= clear_ff + rcpa_pkg::ADDR_WIDTH'(1);
         end
         if (cmd.commit) begin
            top_ff       <= top_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         op_ff   <= req_op;
         page_ff <= req_page;
      end
      if (cmd.commit) begin
         np_ff         <= stk_rd_ff;
         rsp_page_ff   <= res_page;
         rsp_status_ff <= res_status;
         rsp_copy_ff   <= res_copy;
         rsp_count_ff  <= rcpa_pkg::cnt_out(res_count);
      end
   end

   assign stat.rsp_valid   = rsp_valid_ff;
   assign stat.fill_needed = fill_c;
   assign stat.clear_last  = clear_ff == rcpa_pkg::ADDR_WIDTH'(rcpa_pkg::NUM_PAGES - 1);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_copy_needed = rsp_copy_ff;
   assign rsp_ref_count   = rsp_count_ff;

   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= rcpa_pkg::TOP_WIDTH'(rcpa_pkg::NUM_PAGES))
      else $error("stack top beyond capacity");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && stk_we_c) |-> !stack_full)
      else $error("push onto a full free stack");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without a result");

endmodule

[hdl/refcounted_page_allocator.sv]
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// page allocator with a lifo free stack and saturating per-page ref counts
// ----------------------------------------------------------------------------
// result path: an accepted request is read, evaluated and committed to the
//   result register, raising rsp_valid; the commit waits while a stalled result
//   holds the output slot; no request is taken until the commit and any fill;
//   a new-page cow_copy adds a fill, the second write to the single count port
// reset: synchronous; afterwards a clearing pass zeroes all 32768 counts with
//   req_stall high; register writes are taken meanwhile
module refcounted_page_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_op,
   input  logic [rcpa_pkg::PAGE_WIDTH-1:0]       req_page,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rcpa_pkg::PAGE_WIDTH-1:0]       rsp_result_page,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_copy_needed,
   output logic signed [rcpa_pkg::OUT_WIDTH-1:0] rsp_ref_count,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rcpa_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [rcpa_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [rcpa_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);

   // lowest page that free accepts
   logic [rcpa_pkg::PAGE_WIDTH-1:0] first_usable_ff;
   logic                            csr_write;
   logic                            csr_hit;

   rcpa_pkg::dp_cmd_type    cmd;
   rcpa_pkg::dp_status_type stat;

   // register index sits above the byte offset
   assign csr_hit   = paddr[rcpa_pkg::CSR_ADDR_WIDTH-1] == rcpa_pkg::REG_FIRST_USABLE;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
      end else if (csr_write && csr_hit) begin
         first_usable_ff <= pwdata[rcpa_pkg::PAGE_WIDTH-1:0];
      end
   end

   // read back, unmapped addresses return zero
   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = rcpa_pkg::CSR_DATA_WIDTH'(first_usable_ff);
      end
   end

   // sequencer: clear pass, then issue / commit, plus the extra cow write
   rcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // count table, free stack and the result register
   rcpa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_page          (req_page),
      .first_usable_page (first_usable_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_page   (rsp_result_page),
      .rsp_status        (rsp_status),
      .rsp_copy_needed   (rsp_copy_needed),
      .rsp_ref_count     (rsp_ref_count)
   );

endmodule

[verif/tb_refcounted_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator
// Drives allocate, free, count and copy-on-write requests into the page
// allocator and checks every response against a cycle-free predictor kept
// in the bench. A directed table covers the corner cases. Random traffic
// then runs under three backpressure mixes.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator;

   // opcodes the block does not define; they must echo the page untouched
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   localparam logic [rcpa_pkg::CSR_ADDR_WIDTH-1:0] FIRST_USABLE_ADDR =
      rcpa_pkg::CSR_ADDR_WIDTH'(4 * rcpa_pkg::REG_FIRST_USABLE);

   localparam int HOLD_CYCLES = 400;  // long response hold-off
   localparam int LIVE_DEPTH  = 16;   // recently handed-out pages kept for reuse

   // one response as the block should return it
   typedef struct packed {
      rcpa_pkg::page_type        page;
      rcpa_pkg::status_code_type status;
      logic                      copy_needed;
      logic [15:0]               ref_count;
   } outcome_type;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic [2:0]         op;
      rcpa_pkg::page_type page;
      logic               typed;
      outcome_type        want;
   } stim_row_type;

   // directed table, run with first usable page 0x0100 and an empty stack
   localparam int NUM_DIR = 24;
   stim_row_type dir_rows [NUM_DIR] = '{
      // alloc right after reset: stack empty
      '{rcpa_pkg::OP_ALLOC, 15'h0000, 1'b1,
        '{15'h0000, rcpa_pkg::ST_OOM, 1'b0, 16'h0000}},
      // cow_copy on an unshared page hands back the same page
      '{rcpa_pkg::OP_COW_COPY, 15'h0005, 1'b1,
        '{15'h0005, rcpa_pkg::ST_OK, 1'b0, 16'h0000}},
      // free just below and far below the first usable page
      '{rcpa_pkg::OP_FREE, 15'h00FF, 1'b1,
        '{15'h00FF, rcpa_pkg::ST_BAD, 1'b0, 16'h0000}},
      '{rcpa_pkg::OP_FREE, 15'h0000, 1'b1,
        '{15'h0000, rcpa_pkg::ST_BAD, 1'b0, 16'h0000}},
      // free of the top page from a cleared count goes to -1 and is stacked
      '{rcpa_pkg::OP_FREE, 15'h7FFF, 1'b1,
        '{15'h7FFF, rcpa_pkg::ST_OK, 1'b0, 16'hFFFF}},
      // undefined opcodes, then the stacked page is popped and shared
      '{OP_SPARE5,             15'h2AAA, 1'b0, '0},
      '{OP_SPARE6,             15'h5555, 1'b0, '0},
      '{OP_SPARE7,             15'h7FFF, 1'b0, '0},
      '{rcpa_pkg::OP_ALLOC,    15'h0000, 1'b0, '0},
      '{rcpa_pkg::OP_REF_UP,   15'h7FFF, 1'b0, '0},
      // shared page, nothing left to copy into
      '{rcpa_pkg::OP_COW_COPY, 15'h7FFF, 1'b1,
        '{15'h7FFF, rcpa_pkg::ST_OOM, 1'b0, 16'h0002}},
      // free exactly at the first usable page
      '{rcpa_pkg::OP_FREE,     15'h0100, 1'b0, '0},
      // shared page with a spare: new page, copy flagged
      '{rcpa_pkg::OP_COW_COPY, 15'h7FFF, 1'b0, '0},
      '{rcpa_pkg::OP_REF_DOWN, 15'h1234, 1'b0, '0},
      // double free from a negative count
      '{rcpa_pkg::OP_FREE,     15'h1234, 1'b0, '0},
      '{rcpa_pkg::OP_ALLOC,    15'h0000, 1'b0, '0},
      // count changes are allowed below the first usable page
      '{rcpa_pkg::OP_REF_UP,   15'h0000, 1'b0, '0},
      '{rcpa_pkg::OP_REF_DOWN, 15'h0000, 1'b0, '0},
      '{rcpa_pkg::OP_COW_COPY, 15'h0100, 1'b0, '0},
      // same page stacked twice, popped twice
      '{rcpa_pkg::OP_FREE,     15'h7FFF, 1'b0, '0},
      '{rcpa_pkg::OP_FREE,     15'h7FFF, 1'b0, '0},
      '{rcpa_pkg::OP_ALLOC,    15'h0000, 1'b0, '0},
      '{rcpa_pkg::OP_ALLOC,    15'h0000, 1'b0, '0},
      '{rcpa_pkg::OP_ALLOC,    15'h0000, 1'b1,
        '{15'h0000, rcpa_pkg::ST_OOM, 1'b0, 16'h0000}}
   };

   // dut inputs, all known from time zero
   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [2:0]                            req_op = rcpa_pkg::OP_ALLOC;
   rcpa_pkg::page_type                    req_page = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [rcpa_pkg::PAGE_WIDTH-1:0]       rsp_result_page;
   logic [1:0]                            rsp_status;
   logic                                  rsp_copy_needed;
   logic signed [rcpa_pkg::OUT_WIDTH-1:0] rsp_ref_count;
   logic                                  psel = 1'b0;
   logic                                  penable = 1'b0;
   logic                                  pwrite = 1'b0;
   logic [rcpa_pkg::CSR_ADDR_WIDTH-1:0]   paddr = '0;
   logic [rcpa_pkg::CSR_DATA_WIDTH-1:0]   pwdata = '0;
   logic [rcpa_pkg::CSR_DATA_WIDTH-1:0]   prdata;
   logic                                  pready;

   // predictor state: count table, free stack and the one register
   rcpa_pkg::count_type cnt_tbl [rcpa_pkg::NUM_PAGES];
   rcpa_pkg::page_type  free_stack [rcpa_pkg::NUM_PAGES];
   int                  stack_depth = 0;
   rcpa_pkg::page_type  first_usable = '0;

   outcome_type         pending [$];     // responses still owed by the block, oldest first
   rcpa_pkg::page_type  live_pages [$];  // pages recently handed out, reused by random traffic

   int n_errors      = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_pulses   = 0;      // bumped by the sequencer to request a long hold-off

   refcounted_page_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_page        (req_page),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_page (rsp_result_page),
      .rsp_status      (rsp_status),
      .rsp_copy_needed (rsp_copy_needed),
      .rsp_ref_count   (rsp_ref_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      n_errors++;
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // saturating count step at the configured count width
   function automatic rcpa_pkg::count_type step_count(input rcpa_pkg::count_type c,
                                                      input int delta);
      int v;
      v = int'(c) + delta;
      if (v > int'(rcpa_pkg::CNT_MAX)) v = int'(rcpa_pkg::CNT_MAX);
      if (v < int'(rcpa_pkg::CNT_MIN)) v = int'(rcpa_pkg::CNT_MIN);
      return rcpa_pkg::count_type'(v);
   endfunction

   // applies one request to the predictor state and returns its response
   function automatic outcome_type predict_page_op(input logic [2:0] op,
                                                   input rcpa_pkg::page_type pg);
      outcome_type        r;
      rcpa_pkg::page_type np;
      r = '{page: pg, status: rcpa_pkg::ST_OK, copy_needed: 1'b0, ref_count: cnt_tbl[pg]};
      case (op)
         rcpa_pkg::OP_ALLOC: begin
            if (stack_depth == 0) begin
               r = '{page: '0, status: rcpa_pkg::ST_OOM, copy_needed: 1'b0, ref_count: '0};
            end else begin
               stack_depth--;
               np = free_stack[stack_depth];
               cnt_tbl[np] = rcpa_pkg::CNT_ONE;
               r.page = np;
               r.ref_count = cnt_tbl[np];
            end
         end
         rcpa_pkg::OP_FREE: begin
            if (pg < first_usable) begin
               r.status = rcpa_pkg::ST_BAD;
            end else begin
               cnt_tbl[pg] = step_count(cnt_tbl[pg], -1);
               // zero or below goes back on the stack, double frees included
               if (cnt_tbl[pg] <= 0) begin
                  if (stack_depth >= rcpa_pkg::NUM_PAGES) begin
                     r.status = rcpa_pkg::ST_FULL;
                  end else begin
                     free_stack[stack_depth] = pg;
                     stack_depth++;
                  end
               end
               r.ref_count = cnt_tbl[pg];
            end
         end
         rcpa_pkg::OP_REF_UP: begin
            cnt_tbl[pg] = step_count(cnt_tbl[pg], 1);
            r.ref_count = cnt_tbl[pg];
         end
         rcpa_pkg::OP_REF_DOWN: begin
            cnt_tbl[pg] = step_count(cnt_tbl[pg], -1);
            r.ref_count = cnt_tbl[pg];
         end
         rcpa_pkg::OP_COW_COPY: begin
            if (cnt_tbl[pg] > 1) begin
               if (stack_depth == 0) begin
                  r.status = rcpa_pkg::ST_OOM;
               end else begin
                  // new page first, then the old page loses one sharer
                  stack_depth--;
                  np = free_stack[stack_depth];
                  cnt_tbl[np] = rcpa_pkg::CNT_ONE;
                  cnt_tbl[pg] = step_count(cnt_tbl[pg], -1);
                  r.page = np;
                  r.copy_needed = 1'b1;
                  r.ref_count = cnt_tbl[pg];
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // offers one request, waits for acceptance, books the expected response
   task automatic send_request(input logic [2:0] op, input rcpa_pkg::page_type pg,
                               input logic typed, input outcome_type want);
      outcome_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_page  <= pg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_page_op(op, pg);
      pending.push_back(typed ? want : pred);
      if (pred.status == rcpa_pkg::ST_OK && (op == rcpa_pkg::OP_ALLOC || pred.copy_needed)) begin
         live_pages.push_back(pred.page);
         if (live_pages.size() > LIVE_DEPTH) void'(live_pages.pop_front());
      end
   endtask

   task automatic stop_requests;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // waits for all owed responses, then lets the pipe settle
   task automatic drain_results(input int limit);
      int waited;
      waited = 0;
      while (pending.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
      if (pending.size() != 0) begin
         report_mismatch("responses never returned", 0, pending.size());
         pending.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // register write, then a read back of the same register
   task automatic write_first_usable(input rcpa_pkg::page_type v);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= FIRST_USABLE_ADDR;
      pwdata  <= 32'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      first_usable = v;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[rcpa_pkg::PAGE_WIDTH-1:0] !== v)
         report_mismatch("first_usable_page read back", prdata, v);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly well-formed traffic on recently handed-out pages, some noise
   task automatic pick_random_request(output logic [2:0] op,
                                      output rcpa_pkg::page_type pg);
      int pick;
      pick = $urandom_range(99);
      if (live_pages.size() != 0 && $urandom_range(9) < 8)
         pg = live_pages[$urandom_range(live_pages.size() - 1)];
      else
         pg = rcpa_pkg::page_type'($urandom_range(rcpa_pkg::NUM_PAGES - 1));
      if (pick < 25)      op = rcpa_pkg::OP_ALLOC;
      else if (pick < 45) op = rcpa_pkg::OP_FREE;
      else if (pick < 60) op = rcpa_pkg::OP_REF_UP;
      else if (pick < 70) op = rcpa_pkg::OP_REF_DOWN;
      else if (pick < 85) op = rcpa_pkg::OP_COW_COPY;
      else if (pick < 92) op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      else begin
         op = 3'($urandom_range(OP_SPARE7));
         pg = rcpa_pkg::page_type'($urandom_range(rcpa_pkg::NUM_PAGES - 1));
      end
   endtask

   task automatic run_random(input int n_items, input int snd_pct, input int rcv_pct,
                             input rcpa_pkg::page_type fu, input logic with_hold);
      logic [2:0]         op;
      rcpa_pkg::page_type pg;
      drain_results(10000);
      write_first_usable(fu);
      send_idle_pct = snd_pct;
      rcv_idle_pct  = rcv_pct;
      // response side freezes while requests keep coming
      if (with_hold) hold_pulses++;
      repeat (n_items) begin
         pick_random_request(op, pg);
         send_request(op, pg, 1'b0, '0);
      end
      stop_requests();
   endtask

   // response side: random stalls, plus a long hold-off when asked
   initial begin : response_stall
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_pulses) begin
            hold_seen = hold_pulses;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_result_page, 0);
         end else begin
            want = pending.pop_front();
            if (rsp_result_page !== want.page)
               report_mismatch("result_page", rsp_result_page, want.page);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_copy_needed !== want.copy_needed)
               report_mismatch("copy_needed", rsp_copy_needed, want.copy_needed);
            if (rsp_ref_count !== want.ref_count)
               report_mismatch("ref_count", rsp_ref_count, want.ref_count);
         end
      end
   end

   // main sequence
   initial begin : sequencer
      foreach (cnt_tbl[i]) cnt_tbl[i] = rcpa_pkg::CNT_ZERO;
      foreach (free_stack[i]) free_stack[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // register is writable during the clearing pass
      write_first_usable(15'h0100);

      // directed corners
      send_idle_pct = 18;
      rcv_idle_pct  = 73;
      foreach (dir_rows[i])
         send_request(dir_rows[i].op, dir_rows[i].page, dir_rows[i].typed, dir_rows[i].want);
      stop_requests();

      // random traffic under three backpressure mixes
      run_random(250, 18, 73,
                 rcpa_pkg::page_type'($urandom_range(1, rcpa_pkg::NUM_PAGES - 2)), 1'b0);
      run_random(250, 73, 18, rcpa_pkg::page_type'(rcpa_pkg::NUM_PAGES - 1), 1'b0);
      run_random(250, 0, 0, '0, 1'b1);

      drain_results(20000);
      repeat (8) @(posedge clock);
      if (n_errors == 0)
         $display("tb_refcounted_page_allocator: done, clean");
      else
         $display("tb_refcounted_page_allocator: done, errors");
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #5000000;
      $display("tb_refcounted_page_allocator: done, errors");
      $finish;
   end

endmodule
